### hdl/pnp_pkg.sv
// Shared types and constants for the point-near-polyline test
`timescale 1ns / 1ps
package pnp_pkg;

  localparam int MAX_VERTICES_DEF = 8;
  localparam int COORD_BITS_DEF   = 12;

  localparam int FIELD_W    = 12;
  localparam int IDX_W      = 3;
  localparam int VC_W       = 4;
  localparam int THICK_W    = 12;
  localparam int XOFF_W     = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VERTEX_COUNT = 2'd0,
    REG_THICKNESS    = 2'd1,
    REG_X_OFFSET     = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [IDX_W-1:0]   idx;
    logic [FIELD_W-1:0] x;
    logic [FIELD_W-1:0] y;
  } pnp_word_t;

  typedef struct packed {
    logic [VC_W-1:0]    vertex_count;
    logic [THICK_W-1:0] thickness;
    logic [XOFF_W-1:0]  x_offset;
  } pnp_cfg_t;

endpackage

### hdl/pnp_ram.sv
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module pnp_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

### hdl/pnp_front.sv
// Front end: accept and classify words, two-entry queue toward the back end
`timescale 1ns / 1ps
module pnp_front #(
  parameter int MAX_VERTICES = pnp_pkg::MAX_VERTICES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  output logic                       in_full,
  input  logic                       in_mode,
  input  logic [pnp_pkg::IDX_W-1:0]  in_vertex_index,
  input  logic [pnp_pkg::FIELD_W-1:0] in_coord_x,
  input  logic [pnp_pkg::FIELD_W-1:0] in_coord_y,
  output logic                       head_valid,
  output pnp_pkg::pnp_word_t         head,
  input  logic                       head_pop
);
  import pnp_pkg::*;

  pnp_word_t  slot_r [2];
  logic [1:0] count_r;
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic       keep;
  logic       push_q;
  logic       pop_q;
  pnp_word_t  word;

  assign in_full    = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head       = slot_r[rd_ptr_r];

  assign keep   = in_mode || (int'(in_vertex_index) < MAX_VERTICES);
  assign push_q = in_push && !in_full && keep;
  assign pop_q  = head_pop && head_valid;

  always_comb begin
    word.op  = in_mode ? OP_QUERY : OP_LOAD;
    word.idx = in_vertex_index;
    word.x   = in_coord_x;
    word.y   = in_coord_y;
  end

  always_ff @(posedge clk) begin
    if (push_q) begin
      slot_r[wr_ptr_r] <= word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      if (push_q) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop_q) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push_q && !pop_q) begin
        count_r <= count_r + 2'd1;
      end else if (pop_q && !push_q) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule

### hdl/pnp_seg.sv
// Five-stage exact segment distance test pipeline
`timescale 1ns / 1ps
module pnp_seg #(
  parameter int COORD_BITS = pnp_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [pnp_pkg::FIELD_W-1:0]   px,
  input  logic [pnp_pkg::FIELD_W-1:0]   py,
  input  logic [COORD_BITS-1:0]         ax,
  input  logic [COORD_BITS-1:0]         ay,
  input  logic [COORD_BITS-1:0]         bx,
  input  logic [COORD_BITS-1:0]         by,
  input  logic [pnp_pkg::XOFF_W-1:0]    x_offset,
  input  logic [2*pnp_pkg::THICK_W-1:0] t2,
  output logic                          hit
);
  import pnp_pkg::*;

  localparam int UW  = ((COORD_BITS > FIELD_W) ? COORD_BITS : FIELD_W) + 1;
  localparam int DW  = UW + 1;
  localparam int PW  = 2 * DW;
  localparam int SW  = PW + 1;
  localparam int ACW = (SW > 33) ? SW : 33;
  localparam int TW  = 2 * THICK_W;
  localparam int LW  = ((TW + SW) > 64) ? (TW + SW) : 64;

  logic [UW-1:0] ax_u, bx_u, ay_u, by_u, px_u, py_u;

  logic                 v1_r, v2_r, v3_r, v4_r;
  logic signed [DW-1:0] s1_dx_r, s1_dy_r, s1_vx_r, s1_vy_r, s1_wx_r, s1_wy_r;
  logic signed [PW-1:0] s2_dxdx_r, s2_dydy_r, s2_vxdx_r, s2_vydy_r;
  logic signed [PW-1:0] s2_vxdy_r, s2_vydx_r, s2_vxvx_r, s2_vyvy_r;
  logic signed [PW-1:0] s2_wxwx_r, s2_wywy_r;
  logic signed [SW-1:0] s3_len2_r, s3_dot_r, s3_cross_r, s3_da_r, s3_db_r;
  logic signed [SW-1:0] ac;
  logic [ACW-1:0]       ac_ext;
  logic                 s4_sel_a_r, s4_sel_b_r, s4_near_a_r, s4_near_b_r, s4_big_r;
  logic [63:0]          s4_ac2_r;
  logic [LW-1:0]        s4_tl_r;
  logic                 hit_r;

  assign ax_u = UW'(ax) + UW'(x_offset);
  assign bx_u = UW'(bx) + UW'(x_offset);
  assign ay_u = UW'(ay);
  assign by_u = UW'(by);
  assign px_u = UW'(px);
  assign py_u = UW'(py);

  assign ac     = (s3_cross_r < 0) ? -s3_cross_r : s3_cross_r;
  assign ac_ext = ACW'($unsigned(ac));
  assign hit    = hit_r;

  always_ff @(posedge clk) begin
    s1_dx_r <= $signed({1'b0, bx_u}) - $signed({1'b0, ax_u});
    s1_dy_r <= $signed({1'b0, by_u}) - $signed({1'b0, ay_u});
    s1_vx_r <= $signed({1'b0, px_u}) - $signed({1'b0, ax_u});
    s1_vy_r <= $signed({1'b0, py_u}) - $signed({1'b0, ay_u});
    s1_wx_r <= $signed({1'b0, px_u}) - $signed({1'b0, bx_u});
    s1_wy_r <= $signed({1'b0, py_u}) - $signed({1'b0, by_u});

    s2_dxdx_r <= PW'(s1_dx_r) * PW'(s1_dx_r);
    s2_dydy_r <= PW'(s1_dy_r) * PW'(s1_dy_r);
    s2_vxdx_r <= PW'(s1_vx_r) * PW'(s1_dx_r);
    s2_vydy_r <= PW'(s1_vy_r) * PW'(s1_dy_r);
    s2_vxdy_r <= PW'(s1_vx_r) * PW'(s1_dy_r);
    s2_vydx_r <= PW'(s1_vy_r) * PW'(s1_dx_r);
    s2_vxvx_r <= PW'(s1_vx_r) * PW'(s1_vx_r);
    s2_vyvy_r <= PW'(s1_vy_r) * PW'(s1_vy_r);
    s2_wxwx_r <= PW'(s1_wx_r) * PW'(s1_wx_r);
    s2_wywy_r <= PW'(s1_wy_r) * PW'(s1_wy_r);

    s3_len2_r  <= SW'(s2_dxdx_r) + SW'(s2_dydy_r);
    s3_dot_r   <= SW'(s2_vxdx_r) + SW'(s2_vydy_r);
    s3_cross_r <= SW'(s2_vxdy_r) - SW'(s2_vydx_r);
    s3_da_r    <= SW'(s2_vxvx_r) + SW'(s2_vyvy_r);
    s3_db_r    <= SW'(s2_wxwx_r) + SW'(s2_wywy_r);

    s4_sel_a_r  <= (s3_dot_r <= 0);
    s4_sel_b_r  <= (s3_dot_r >= s3_len2_r);
    s4_near_a_r <= ($unsigned(s3_da_r) < SW'(t2));
    s4_near_b_r <= ($unsigned(s3_db_r) < SW'(t2));
    s4_big_r    <= ((ac_ext >> 32) != '0);
    s4_ac2_r    <= 64'(ac_ext[31:0]) * 64'(ac_ext[31:0]);
    s4_tl_r     <= LW'(t2) * LW'($unsigned(s3_len2_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      v4_r  <= 1'b0;
      hit_r <= 1'b0;
    end else begin
      v1_r  <= in_valid && !((ax == bx) && (ay == by));
      v2_r  <= v1_r;
      v3_r  <= v2_r;
      v4_r  <= v3_r;
      hit_r <= v4_r && (s4_sel_a_r ? s4_near_a_r :
                        s4_sel_b_r ? s4_near_b_r :
                        (!s4_big_r && (LW'(s4_ac2_r) < s4_tl_r)));
    end
  end

endmodule

### hdl/pnp_back.sv
// Back end: vertex store, segment walk sequencer and result register
`timescale 1ns / 1ps
module pnp_back #(
  parameter int MAX_VERTICES = pnp_pkg::MAX_VERTICES_DEF,
  parameter int COORD_BITS   = pnp_pkg::COORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pnp_pkg::pnp_cfg_t  cfg,
  input  logic               head_valid,
  input  pnp_pkg::pnp_word_t head,
  output logic               head_pop,
  output logic               out_empty,
  input  logic               out_pop,
  output logic               out_hit
);
  import pnp_pkg::*;

  localparam int AW        = $clog2(MAX_VERTICES);
  localparam int NW        = $clog2(MAX_VERTICES + 1);
  localparam int CW        = (NW > VC_W) ? NW : VC_W;
  localparam int VW        = 2 * COORD_BITS;
  localparam int TW        = 2 * THICK_W;
  localparam int DRAIN_CYC = 7;
  localparam int DRW       = 3;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN, ST_DONE} state_t;

  state_t             state_r;
  logic [CW-1:0]      cnt_r;
  logic [CW-1:0]      n_lim;
  logic [CW-1:0]      vc_ext;
  logic [DRW-1:0]     drain_r;
  logic               rd_vld_r;
  logic               rd_first_r;
  logic [VW-1:0]      prev_r;
  logic [VW-1:0]      rdata;
  logic [FIELD_W-1:0] px_r, py_r;
  logic [TW-1:0]      t2_r;
  logic               acc_r;
  logic               out_valid_r;
  logic               out_hit_r;
  logic               issue;
  logic               we;
  logic               seg_hit;

  assign vc_ext    = CW'(cfg.vertex_count);
  assign n_lim     = (vc_ext > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : vc_ext;
  assign issue     = (state_r == ST_RUN) && (cnt_r < n_lim);
  assign we        = (state_r == ST_IDLE) && head_valid && (head.op == OP_LOAD);
  assign head_pop  = (state_r == ST_IDLE) && head_valid;
  assign out_empty = !out_valid_r;
  assign out_hit   = out_hit_r;

  pnp_ram #(
    .WIDTH (VW),
    .DEPTH (MAX_VERTICES)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (AW'(head.idx)),
    .wdata ({COORD_BITS'(head.x), COORD_BITS'(head.y)}),
    .raddr (cnt_r[AW-1:0]),
    .rdata (rdata)
  );

  pnp_seg #(
    .COORD_BITS (COORD_BITS)
  ) u_seg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (rd_vld_r && !rd_first_r),
    .px       (px_r),
    .py       (py_r),
    .ax       (prev_r[VW-1:COORD_BITS]),
    .ay       (prev_r[COORD_BITS-1:0]),
    .bx       (rdata[VW-1:COORD_BITS]),
    .by       (rdata[COORD_BITS-1:0]),
    .x_offset (cfg.x_offset),
    .t2       (t2_r),
    .hit      (seg_hit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      drain_r     <= '0;
      rd_vld_r    <= 1'b0;
      rd_first_r  <= 1'b0;
      acc_r       <= 1'b0;
      out_valid_r <= 1'b0;
      out_hit_r   <= 1'b0;
    end else begin
      rd_vld_r   <= issue;
      rd_first_r <= (cnt_r == '0);
      if (state_r != ST_IDLE) begin
        acc_r <= acc_r | seg_hit;
      end
      if (rd_vld_r) begin
        prev_r <= rdata;
      end
      if (out_pop && out_valid_r && (state_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (head_valid && (head.op == OP_QUERY)) begin
            px_r    <= head.x;
            py_r    <= head.y;
            t2_r    <= TW'(cfg.thickness) * TW'(cfg.thickness);
            cnt_r   <= '0;
            acc_r   <= 1'b0;
            state_r <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (issue) begin
            cnt_r <= cnt_r + CW'(1);
          end else begin
            drain_r <= DRW'(DRAIN_CYC);
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (drain_r == '0) begin
            state_r <= ST_DONE;
          end else begin
            drain_r <= drain_r - DRW'(1);
          end
        end
        ST_DONE: begin
          if (!out_valid_r || out_pop) begin
            out_valid_r <= 1'b1;
            out_hit_r   <= acc_r;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### hdl/point_near_polyline_test.sv
// Load word: written to the vertex RAM in the same cycle that the back end pops it from the input queue.
// Query word: n = vertices in use; the back end reads one vertex per cycle
// from the vertex RAM into a five-stage segment pipeline.
// Throughput: one query at a time; loads retire one per cycle while no query is in progress.
// Reset clears the queues, control state and config registers; the vertex
// RAM is not cleared and holds garbage until loaded.
`timescale 1ns / 1ps
module point_near_polyline_test #(
  parameter int MAX_VERTICES = pnp_pkg::MAX_VERTICES_DEF,
  parameter int COORD_BITS   = pnp_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic                           in_mode,
  input  logic [pnp_pkg::IDX_W-1:0]      in_vertex_index,
  input  logic [pnp_pkg::FIELD_W-1:0]    in_coord_x,
  input  logic [pnp_pkg::FIELD_W-1:0]    in_coord_y,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic                           out_hit,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pnp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pnp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pnp_pkg::*;

  pnp_cfg_t  cfg_r;
  logic      head_valid;
  pnp_word_t head;
  logic      head_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_VERTEX_COUNT: cfg_r.vertex_count <= cfg_data[VC_W-1:0];
        REG_THICKNESS:    cfg_r.thickness    <= cfg_data[THICK_W-1:0];
        REG_X_OFFSET:     cfg_r.x_offset     <= cfg_data[XOFF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  pnp_front #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_mode         (in_mode),
    .in_vertex_index (in_vertex_index),
    .in_coord_x      (in_coord_x),
    .in_coord_y      (in_coord_y),
    .head_valid      (head_valid),
    .head            (head),
    .head_pop        (head_pop)
  );

  pnp_back #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_hit    (out_hit)
  );

endmodule
